// ===== rtl/core/esp_pkg.sv =====
// Package for the encoder speed estimator: widths, register codes, reset values, state type.
package esp_pkg;

    localparam int SCALE_W    = 28;
    localparam int LIMIT_W    = 11;
    localparam int WINDOW_W   = 16;
    localparam int THRESH_W   = 12;
    localparam int ACC_W      = 16;
    localparam int CNT_W      = 16;
    localparam int SPEED_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    // divider: magnitude of accumulator times scale over the period count
    localparam int DIV_W          = ACC_W + SCALE_W;
    localparam int DIVISOR_W      = CNT_W;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_ITER       = DIV_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_ITER);

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DIFF_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD  = 2'd3;

    localparam logic [SCALE_W-1:0]  SCALE_RST  = 28'd409600;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 11'd150;
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd25;
    localparam logic [THRESH_W-1:0] THRESH_RST = 12'd1000;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DLOAD,
        ST_DIV,
        ST_SAT,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/esp_divider.sv =====
// Iterative restoring divider, two quotient bits per cycle, unsigned.
module esp_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [esp_pkg::DIV_W-1:0]      dividend,
    input  logic [esp_pkg::DIVISOR_W-1:0]  divisor,
    output logic                           done,
    output logic [esp_pkg::DIV_W-1:0]      quotient
);
    import esp_pkg::*;

    logic [DIVISOR_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_comb
    begin
        logic [DIVISOR_W:0] r;
        logic [DIV_W-1:0]   q;
        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < DIV_RADIX_BITS; k++)
        begin
            r = {r[DIVISOR_W-1:0], q[DIV_W-1]};
            q = {q[DIV_W-2:0], 1'b0};
            if (r >= {1'b0, dvs_reg})
            begin
                r    = r - {1'b0, dvs_reg};
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_ITER - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/encoder_speed_estimator_top.sv =====
// Encoder speed estimator top level: sequencer, state, shared multiplier and divider.
//
// One absolute position beat in per control period, one speed beat out per
// position. Input: position with in_valid/in_stall. Output: speed and updated
// with out_valid/out_stall. Configuration: cfg_write, cfg_index, cfg_data,
// to be written only while idle; the block itself does not enforce this.
// When the speed is held the input goes straight to ST_OUT; the high-speed
// method passes ST_MUL, ST_SAT and ST_OUT; when the low-speed window closes,
// ST_DLOAD and ST_DIV come between ST_MUL and ST_SAT. The shared divider
// resolves two quotient bits per cycle over 44 bits. One item is in flight at
// a time; in_stall is low only in the idle state. Without stalls the next
// position is taken at the edge that takes the result beat; no new position
// is taken before the block is through with the last one.
// The result sits in an output register; while the receiver stalls, the next
// position is still taken and processed, and the block waits with its new
// result until the register frees.
// Reset clears previous position, accumulator, period counter and held speed,
// loads the register defaults and empties the output register.
module encoder_speed_estimator_top #(
    parameter int POSITION_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [POSITION_BITS-1:0]        position,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [esp_pkg::SPEED_W-1:0] speed,
    output logic                            updated,
    input  logic                            cfg_write,
    input  logic [esp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [esp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import esp_pkg::*;

    localparam int CMP_W  = (POSITION_BITS + 2 > 14) ? POSITION_BITS + 2 : 14;
    localparam int OP_W   = (POSITION_BITS + 1 > ACC_W) ? POSITION_BITS + 1 : ACC_W;
    localparam int PROD_W = OP_W + SCALE_W;
    localparam logic [CMP_W-1:0] TURN = {{(CMP_W-1){1'b0}}, 1'b1} << POSITION_BITS;
    localparam logic signed [PROD_W-1:0] PROD_HI = PROD_W'(64'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] PROD_LO = PROD_W'(-64'sh8000_0000);

    state_t state_reg, state_next;

    logic [SCALE_W-1:0]  scale_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [WINDOW_W-1:0] window_reg;
    logic [THRESH_W-1:0] thresh_reg;

    logic [POSITION_BITS-1:0] prev_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [SPEED_W-1:0] held_reg;
    logic                     upd_reg;
    logic signed [OP_W-1:0]   op_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DIVISOR_W-1:0]     divisor_reg;
    logic                     div_mode_reg;

    logic                     out_valid_reg;
    logic signed [SPEED_W-1:0] out_speed_reg;
    logic                     out_updated_reg;

    logic                     in_accept;
    logic                     out_load;
    logic                     div_start;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quotient;
    logic [DIV_W-1:0]         div_dividend;

    logic signed [CMP_W-1:0]  diff_w;
    logic signed [CMP_W-1:0]  thr_w;
    logic signed [CMP_W-1:0]  unw_w;
    logic signed [CMP_W-1:0]  mag_w;
    logic                     slow;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     win_hit;
    logic [ACC_W-1:0]         acc_new;
    logic signed [OP_W+SCALE_W:0] mul_full;
    logic signed [PROD_W-1:0] prod_abs;
    logic signed [SPEED_W-1:0] sat_speed;

    // position difference, unwrap, method select
    always_comb
    begin
        diff_w = CMP_W'(prev_reg) - CMP_W'(position);
        thr_w  = CMP_W'(thresh_reg);
        if (diff_w > thr_w)
            unw_w = diff_w - TURN;
        else if (diff_w < -thr_w)
            unw_w = diff_w + TURN;
        else
            unw_w = diff_w;
        mag_w   = (unw_w < 0) ? -unw_w : unw_w;
        slow    = mag_w < CMP_W'(limit_reg);
        cnt_inc = cnt_reg + 1'b1;
        win_hit = cnt_inc > window_reg;
        acc_new = acc_reg + ACC_W'(unw_w);
    end

    assign mul_full     = op_reg * $signed({1'b0, scale_reg});
    assign prod_abs     = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign div_dividend = prod_abs[DIV_W-1:0];

    always_comb
    begin
        if (div_mode_reg)
        begin
            if (!prod_reg[PROD_W-1])
                sat_speed = (div_quotient > DIV_W'(SPEED_MAX)) ? SPEED_MAX
                                                               : div_quotient[SPEED_W-1:0];
            else
                sat_speed = (div_quotient > DIV_W'(SPEED_MIN)) ? SPEED_MIN
                                                               : -div_quotient[SPEED_W-1:0];
        end
        else
        begin
            if (prod_reg > PROD_HI)
                sat_speed = SPEED_MAX;
            else if (prod_reg < PROD_LO)
                sat_speed = SPEED_MIN;
            else
                sat_speed = prod_reg[SPEED_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = (slow && !win_hit) ? ST_OUT : ST_MUL;
            end
            ST_MUL:   state_next = div_mode_reg ? ST_DLOAD : ST_SAT;
            ST_DLOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_SAT;
            end
            ST_SAT:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:  in_stall  = 1'b0;
            ST_DLOAD: div_start = 1'b1;
            ST_OUT:   out_load  = !out_valid_reg || !out_stall;
            default:  in_stall  = 1'b1;
        endcase
    end

    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RST;
            limit_reg  <= LIMIT_RST;
            window_reg <= WINDOW_RST;
            thresh_reg <= THRESH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SPEED_SCALE:     scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_SLOW_DIFF_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_WINDOW_LENGTH:   window_reg <= cfg_data[WINDOW_W-1:0];
                REG_WRAP_THRESHOLD:  thresh_reg <= cfg_data[THRESH_W-1:0];
                default:             scale_reg  <= scale_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            held_reg <= '0;
            upd_reg  <= 1'b0;
            div_mode_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            prev_reg <= position;
            if (slow)
            begin
                if (win_hit)
                begin
                    acc_reg      <= '0;
                    cnt_reg      <= '0;
                    div_mode_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= acc_new;
                    cnt_reg <= cnt_inc;
                    upd_reg <= 1'b0;
                end
            end
            else
            begin
                acc_reg      <= '0;
                cnt_reg      <= cnt_inc;
                div_mode_reg <= 1'b0;
            end
        end
        else if (state_reg == ST_SAT)
        begin
            held_reg <= sat_speed;
            upd_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg      <= slow ? OP_W'($signed(acc_new)) : OP_W'(unw_w);
            divisor_reg <= cnt_inc;
        end
        if (state_reg == ST_MUL)
            prod_reg <= mul_full[PROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_speed_reg   <= held_reg;
            out_updated_reg <= upd_reg;
        end
    end

    esp_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_valid = out_valid_reg;
    assign speed     = out_speed_reg;
    assign updated   = out_updated_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DLOAD |-> divisor_reg != '0)
        else $error("divide started with zero period count");

    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_valid_reg) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not moved to output register");

endmodule
